FILE: rtl/tslt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tslt_pkg
// Shared types and constants of the transmit slot lifecycle tracker.
// ----------------------------------------------------------------------------
package tslt_pkg;

    // Number of slot bit positions that exist in hardware (2 .. 32)
    localparam int SLOTS = 32;

    // Field widths
    localparam int REQ_W   = 4;
    localparam int SLOT_W  = 5;
    localparam int MAP_W   = 32;
    localparam int QCODE_W = 2;
    localparam int COUNT_W = 6;

    // Bits that hold a slot at all
    localparam logic [MAP_W-1:0] SLOT_LIMIT = MAP_W'((64'd1 << SLOTS) - 64'd1);

    // Event codes
    typedef enum logic [REQ_W-1:0] {
        REQ_INIT     = 4'd0,
        REQ_CLAIM    = 4'd1,
        REQ_FILL     = 4'd2,
        REQ_TRIGGER  = 4'd3,
        REQ_SUBMIT   = 4'd4,
        REQ_ABORT    = 4'd5,
        REQ_COMPLETE = 4'd6,
        REQ_RESTART  = 4'd7,
        REQ_QUEUE    = 4'd8
    } t_req;

    // Queue state and request codes
    localparam logic [QCODE_W-1:0] Q_RUNNABLE = 2'd0;
    localparam logic [QCODE_W-1:0] Q_STOPPED  = 2'd1;
    localparam logic [QCODE_W-1:0] Q_STARTED  = 2'd2;
    localparam logic [QCODE_W-1:0] Q_RESTART  = 2'd3;

    // Configuration register indexes
    localparam logic CFG_FIRST_SLOT = 1'b0;
    localparam logic CFG_SLOT_COUNT = 1'b1;

    // Request from the slot core to the queue machine
    typedef struct packed {
        logic               init;
        logic               ask;
        logic [QCODE_W-1:0] code;
    } t_q_req;

    // Queue machine result for the current item
    typedef struct packed {
        logic               wake;
        logic               stop;
        logic [QCODE_W-1:0] state;
    } t_q_out;

endpackage

FILE: rtl/tx_slot_lifecycle_tracker_top.sv
`timescale 1ns / 1ps
// The item is captured in the input register when accepted; the result strobe
// rises in the cycle after that, from the result register.
// Throughput: one item per cycle; busy stays low, so start may be high
// in every cycle. The bitmap next-state logic and lowest-bit encoder sit
// combinationally between input and result registers and allow this rate.
// Reset: synchronous, active low; clears all stage bitmaps, sets the queue
// to runnable, first_slot to 1 and slot_count to 8. The receiver cannot stall.
// ----------------------------------------------------------------------------
// tx_slot_lifecycle_tracker_top
// Transmit slot lifecycle tracker: input register, stage core, queue
// machine and result register, plus the configuration registers.
// ----------------------------------------------------------------------------
module tx_slot_lifecycle_tracker_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // item channel
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [tslt_pkg::REQ_W-1:0]    i_req_type,
    input  logic [tslt_pkg::SLOT_W-1:0]   i_slot,
    input  logic [tslt_pkg::MAP_W-1:0]    i_hw_request_bits,
    input  logic [tslt_pkg::QCODE_W-1:0]  i_requested_state,
    // configuration channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [tslt_pkg::COUNT_W-1:0]  i_cfg_data,
    // results
    output logic                          o_res_valid,
    output logic                          o_granted,
    output logic                          o_busy_res,
    output logic [tslt_pkg::SLOT_W-1:0]   o_granted_slot,
    output logic [tslt_pkg::MAP_W-1:0]    o_finished_bits,
    output logic                          o_wake_queue,
    output logic                          o_stop_queue,
    output logic [tslt_pkg::QCODE_W-1:0]  o_queue_state_out,
    output logic                          o_restart_done
);

    logic                          r_in_valid;
    logic [tslt_pkg::REQ_W-1:0]    r_req_type;
    logic [tslt_pkg::SLOT_W-1:0]   r_slot;
    logic [tslt_pkg::MAP_W-1:0]    r_hw_request_bits;
    logic [tslt_pkg::QCODE_W-1:0]  r_requested_state;
    logic [tslt_pkg::SLOT_W-1:0]   r_first_slot;
    logic [tslt_pkg::COUNT_W-1:0]  r_slot_count;

    logic                          w_granted;
    logic                          w_busy_res;
    logic [tslt_pkg::SLOT_W-1:0]   w_granted_slot;
    logic [tslt_pkg::MAP_W-1:0]    w_finished_bits;
    logic                          w_restart_done;
    tslt_pkg::t_q_req              w_q_req;
    tslt_pkg::t_q_out              w_q;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Capture the item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_start && !o_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req_type        <= i_req_type;
        r_slot            <= i_slot;
        r_hw_request_bits <= i_hw_request_bits;
        r_requested_state <= i_requested_state;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_slot <= tslt_pkg::SLOT_W'(1);
            r_slot_count <= tslt_pkg::COUNT_W'(8);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                tslt_pkg::CFG_FIRST_SLOT: r_first_slot <= i_cfg_data[tslt_pkg::SLOT_W-1:0];
                tslt_pkg::CFG_SLOT_COUNT: r_slot_count <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    tslt_stage_core u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (r_in_valid),
        .i_req_type        (r_req_type),
        .i_slot            (r_slot),
        .i_hw_request_bits (r_hw_request_bits),
        .i_requested_state (r_requested_state),
        .i_first_slot      (r_first_slot),
        .i_slot_count      (r_slot_count),
        .o_granted         (w_granted),
        .o_busy_res        (w_busy_res),
        .o_granted_slot    (w_granted_slot),
        .o_finished_bits   (w_finished_bits),
        .o_restart_done    (w_restart_done),
        .o_q_req           (w_q_req)
    );

    tslt_queue_fsm u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q_req (w_q_req),
        .o_q     (w_q)
    );

    // Register the result and strobe it for one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_res_valid <= 1'b0;
        end else begin
            o_res_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_granted         <= w_granted;
        o_busy_res        <= w_busy_res;
        o_granted_slot    <= w_granted_slot;
        o_finished_bits   <= w_finished_bits;
        o_wake_queue      <= w_q.wake;
        o_stop_queue      <= w_q.stop;
        o_queue_state_out <= w_q.state;
        o_restart_done    <= w_restart_done;
    end

    // Every captured item yields exactly one result in the next cycle
    a_item_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |=> o_res_valid)
        else $error("captured item produced no result");

    a_no_phantom_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |=> !o_res_valid)
        else $error("result without a captured item");

    a_grant_or_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !(o_granted && o_busy_res))
        else $error("claim both granted and busy");

    a_one_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !(o_wake_queue && o_stop_queue))
        else $error("wake and stop in the same result");

    a_queue_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_queue_state_out != tslt_pkg::Q_RESTART))
        else $error("queue state reports restart code");

endmodule

FILE: rtl/tslt_stage_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tslt_stage_core
// Five stage bitmaps, lowest-idle-slot encoder and event decode. Updates the
// bitmaps for the item held in the input register.
// ----------------------------------------------------------------------------
module tslt_stage_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [tslt_pkg::REQ_W-1:0]    i_req_type,
    input  logic [tslt_pkg::SLOT_W-1:0]   i_slot,
    input  logic [tslt_pkg::MAP_W-1:0]    i_hw_request_bits,
    input  logic [tslt_pkg::QCODE_W-1:0]  i_requested_state,
    input  logic [tslt_pkg::SLOT_W-1:0]   i_first_slot,
    input  logic [tslt_pkg::COUNT_W-1:0]  i_slot_count,
    output logic                          o_granted,
    output logic                          o_busy_res,
    output logic [tslt_pkg::SLOT_W-1:0]   o_granted_slot,
    output logic [tslt_pkg::MAP_W-1:0]    o_finished_bits,
    output logic                          o_restart_done,
    output tslt_pkg::t_q_req              o_q_req
);

    logic [tslt_pkg::MAP_W-1:0]   r_idle, r_fill, r_trig, r_bus, r_done;
    logic [tslt_pkg::MAP_W-1:0]   n_idle, n_fill, n_trig, n_bus, n_done;
    logic [tslt_pkg::COUNT_W-1:0] w_count;
    logic [tslt_pkg::MAP_W:0]     w_ones;
    logic [tslt_pkg::MAP_W-1:0]   w_range;
    logic [tslt_pkg::MAP_W-1:0]   w_low;
    logic [tslt_pkg::SLOT_W-1:0]  w_low_idx;
    logic [tslt_pkg::MAP_W-1:0]   w_bit;

    // Slot range mask from configuration, clipped to 32 and to SLOTS
    always_comb begin
        w_count = (i_slot_count > tslt_pkg::COUNT_W'(tslt_pkg::MAP_W))
                ? tslt_pkg::COUNT_W'(tslt_pkg::MAP_W) : i_slot_count;
        w_ones  = ((tslt_pkg::MAP_W+1)'(1) << w_count) - (tslt_pkg::MAP_W+1)'(1);
        w_range = (w_ones[tslt_pkg::MAP_W-1:0] << i_first_slot) & tslt_pkg::SLOT_LIMIT;
    end

    // Isolate the lowest idle slot and encode its index
    assign w_low = r_idle & (~r_idle + tslt_pkg::MAP_W'(1));
    always_comb begin
        w_low_idx = '0;
        for (int i = 0; i < tslt_pkg::MAP_W; i++) begin
            if (w_low[i]) begin
                w_low_idx = w_low_idx | tslt_pkg::SLOT_W'(i);
            end
        end
    end

    assign w_bit = tslt_pkg::MAP_W'(1) << i_slot;

    // Decode the event and build next bitmaps and result fields
    always_comb begin
        n_idle          = r_idle;
        n_fill          = r_fill;
        n_trig          = r_trig;
        n_bus           = r_bus;
        n_done          = r_done;
        o_granted       = 1'b0;
        o_busy_res      = 1'b0;
        o_granted_slot  = '0;
        o_finished_bits = '0;
        o_restart_done  = 1'b0;
        o_q_req         = '0;
        if (i_valid) begin
            unique case (i_req_type) inside
                tslt_pkg::REQ_INIT: begin
                    n_idle       = w_range;
                    n_fill       = '0;
                    n_trig       = '0;
                    n_bus        = '0;
                    n_done       = '0;
                    o_q_req.init = 1'b1;
                end
                tslt_pkg::REQ_CLAIM: begin
                    if (r_idle == '0) begin
                        o_busy_res = 1'b1;
                    end else begin
                        n_idle         = r_idle & ~w_low;
                        n_fill         = r_fill | w_low;
                        o_granted      = 1'b1;
                        o_granted_slot = w_low_idx;
                        if ((r_idle & ~w_low) == '0) begin
                            o_q_req.ask  = 1'b1;
                            o_q_req.code = tslt_pkg::Q_RUNNABLE;
                        end
                    end
                end
                tslt_pkg::REQ_FILL: begin
                    if ((r_fill & w_bit) != '0) begin
                        n_fill = r_fill & ~w_bit;
                        n_trig = r_trig | w_bit;
                    end
                end
                tslt_pkg::REQ_TRIGGER: begin
                    if ((r_trig & w_bit) != '0) begin
                        n_trig = r_trig & ~w_bit;
                        n_bus  = r_bus | w_bit;
                    end
                end
                tslt_pkg::REQ_SUBMIT, tslt_pkg::REQ_ABORT: begin
                    if ((r_bus & w_bit) != '0) begin
                        n_bus  = r_bus & ~w_bit;
                        n_done = r_done | w_bit;
                    end
                end
                tslt_pkg::REQ_COMPLETE: begin
                    o_finished_bits = r_bus & ~i_hw_request_bits & w_range;
                end
                tslt_pkg::REQ_RESTART: begin
                    if ((r_idle | r_fill | r_trig | r_bus) == '0) begin
                        n_idle         = r_idle | r_done;
                        n_done         = '0;
                        o_restart_done = 1'b1;
                        o_q_req.ask    = 1'b1;
                        o_q_req.code   = tslt_pkg::Q_RESTART;
                    end
                end
                tslt_pkg::REQ_QUEUE: begin
                    o_q_req.ask  = 1'b1;
                    o_q_req.code = i_requested_state;
                end
                default: begin
                    // unused event codes leave everything as is
                end
            endcase
        end
    end

    // Hold the stage bitmaps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle <= '0;
            r_fill <= '0;
            r_trig <= '0;
            r_bus  <= '0;
            r_done <= '0;
        end else begin
            r_idle <= n_idle;
            r_fill <= n_fill;
            r_trig <= n_trig;
            r_bus  <= n_bus;
            r_done <= n_done;
        end
    end

endmodule

FILE: rtl/tslt_queue_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tslt_queue_fsm
// Queue state machine: runnable, stopped, started. Gives wake and stop
// pulses and the state after the current item.
// ----------------------------------------------------------------------------
module tslt_queue_fsm (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tslt_pkg::t_q_req  i_q_req,
    output tslt_pkg::t_q_out  o_q
);

    typedef enum logic [2:0] {
        QS_RUNNABLE = 3'b001,
        QS_STOPPED  = 3'b010,
        QS_STARTED  = 3'b100
    } t_qstate;

    t_qstate r_state, n_state;

    // Next state, pulses and the encoded state after the item
    always_comb begin
        n_state  = r_state;
        o_q.wake = 1'b0;
        o_q.stop = 1'b0;
        if (i_q_req.init) begin
            n_state = QS_RUNNABLE;
        end else if (i_q_req.ask) begin
            unique case (r_state)
                QS_RUNNABLE: begin
                    if (i_q_req.code == tslt_pkg::Q_STARTED ||
                        i_q_req.code == tslt_pkg::Q_RESTART) begin
                        o_q.wake = 1'b1;
                        n_state  = QS_STARTED;
                    end
                end
                QS_STOPPED: begin
                    if (i_q_req.code == tslt_pkg::Q_STARTED) begin
                        o_q.wake = 1'b1;
                        n_state  = QS_STARTED;
                    end
                end
                QS_STARTED: begin
                    if (i_q_req.code == tslt_pkg::Q_RUNNABLE) begin
                        o_q.stop = 1'b1;
                        n_state  = QS_RUNNABLE;
                    end else if (i_q_req.code == tslt_pkg::Q_STOPPED) begin
                        o_q.stop = 1'b1;
                        n_state  = QS_STOPPED;
                    end
                end
                default: begin
                    n_state = QS_RUNNABLE;
                end
            endcase
        end

        // Encode the state after the item
        unique case (n_state)
            QS_STOPPED: o_q.state = tslt_pkg::Q_STOPPED;
            QS_STARTED: o_q.state = tslt_pkg::Q_STARTED;
            default:    o_q.state = tslt_pkg::Q_RUNNABLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= QS_RUNNABLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
